/* design/smbs_pkg.sv */
// Shared constants and controller/datapath interface types for the sorted matrix search core.
package smbs_pkg;

  // Default table geometry and element width
  localparam int MAX_ROWS_DEF      = 16;
  localparam int MAX_COLS_DEF      = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CNT_W   = 5;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Request action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Register index codes (paddr[2])
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1);

  typedef struct packed {
    logic load_we;   // write one table entry
    logic start;     // set up bounds and target for a search
    logic probe;     // latch midpoint, read table at it
    logic step;      // narrow bounds after a mismatch
  } cmd_t;

  typedef struct packed {
    logic empty;     // live range holds no entry
    logic equal;     // probed entry matches target
  } sts_t;

endpackage

/* design/sorted_matrix_binary_search_core.sv */
// Sorted matrix search core: a load request (action 0) writes one signed element at a
// row-major flat position and returns nothing; loads past the table are dropped.
// A search request (action 1) binary-searches positions 0 to rows*cols-1 and returns one
// found flag. Each probe reads the table through its registered read port and then compares.
// One request is in flight at a time; a finished result waits in the output register while
// the next request is taken. Row and column counts are written over APB (row at 0x0, column
// at 0x4); the user must write them only while idle, as the block does not enforce it.
// Values above the table geometry clamp to it.
// Table contents are undefined until loaded, so load every position in use before searching.
module sorted_matrix_binary_search_core #(
  parameter int MAX_ROWS      = smbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS      = smbs_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_WIDTH = smbs_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic [smbs_pkg::POS_W-1:0]          in_position,
  input  logic signed [smbs_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smbs_pkg::APB_AW-1:0]         paddr,
  input  logic [smbs_pkg::APB_DW-1:0]         pwdata,
  output logic [smbs_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  smbs_pkg::cmd_t             cmd;
  smbs_pkg::sts_t             sts;
  logic [smbs_pkg::CNT_W-1:0] row_count;
  logic [smbs_pkg::CNT_W-1:0] col_count;

  smbs_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_count (row_count),
    .col_count (col_count)
  );

  smbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_found (out_found),
    .cmd       (cmd),
    .sts       (sts)
  );

  smbs_datapath #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .in_position (in_position),
    .in_value    (in_value),
    .row_count   (row_count),
    .col_count   (col_count)
  );

endmodule

/* design/smbs_regs.sv */
// APB configuration registers: row and column counts.
module smbs_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smbs_pkg::APB_AW-1:0]     paddr,
  input  logic [smbs_pkg::APB_DW-1:0]     pwdata,
  output logic [smbs_pkg::APB_DW-1:0]     prdata,
  output logic                            pready,
  output logic [smbs_pkg::CNT_W-1:0]      row_count,
  output logic [smbs_pkg::CNT_W-1:0]      col_count
);

  logic [smbs_pkg::CNT_W-1:0] row_count_r, row_count_nxt;
  logic [smbs_pkg::CNT_W-1:0] col_count_r, col_count_nxt;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (wr_en) begin
      case (reg_sel)
        smbs_pkg::REG_ROW_COUNT: row_count_nxt = pwdata[smbs_pkg::CNT_W-1:0];
        smbs_pkg::REG_COL_COUNT: col_count_nxt = pwdata[smbs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= smbs_pkg::COUNT_RESET;
      col_count_r <= smbs_pkg::COUNT_RESET;
    end else begin
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      smbs_pkg::REG_ROW_COUNT: prdata = smbs_pkg::APB_DW'(row_count_r);
      smbs_pkg::REG_COL_COUNT: prdata = smbs_pkg::APB_DW'(col_count_r);
      default:                 prdata = '0;
    endcase
  end

  assign row_count = row_count_r;
  assign col_count = col_count_r;

endmodule

/* design/smbs_datapath.sv */
// Search datapath: element table, search bounds, midpoint and compare.
module smbs_datapath #(
  parameter int MAX_ROWS      = smbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS      = smbs_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_WIDTH = smbs_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  smbs_pkg::cmd_t                    cmd,
  output smbs_pkg::sts_t                    sts,
  input  logic [smbs_pkg::POS_W-1:0]        in_position,
  input  logic signed [smbs_pkg::VALUE_W-1:0] in_value,
  input  logic [smbs_pkg::CNT_W-1:0]        row_count,
  input  logic [smbs_pkg::CNT_W-1:0]        col_count
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = $clog2(DEPTH + 1);
  localparam int CUT_W = (ELEMENT_WIDTH < smbs_pkg::VALUE_W) ? ELEMENT_WIDTH
                                                             : smbs_pkg::VALUE_W;
  localparam int SZ_W  = 2 * smbs_pkg::CNT_W;

  logic signed [ELEMENT_WIDTH-1:0] mem [DEPTH];

  logic [BW-1:0]                   lo_r, hi_r, mid_r;
  logic signed [ELEMENT_WIDTH-1:0] target_r;
  logic signed [ELEMENT_WIDTH-1:0] rdata_r;

  logic [smbs_pkg::CNT_W-1:0]      rows_eff, cols_eff;
  logic [SZ_W-1:0]                 size_w;
  logic signed [CUT_W-1:0]         val_cut;
  logic signed [ELEMENT_WIDTH-1:0] val_elem;
  logic [BW-1:0]                   span_w, mid_w;
  logic                            pos_ok;

  // Counts above the table geometry clamp to it
  assign rows_eff = (32'(row_count) > MAX_ROWS) ? smbs_pkg::CNT_W'(MAX_ROWS) : row_count;
  assign cols_eff = (32'(col_count) > MAX_COLS) ? smbs_pkg::CNT_W'(MAX_COLS) : col_count;
  assign size_w   = rows_eff * cols_eff;

  // Narrow elements keep the low bits; wide elements take the value sign-extended
  assign val_cut  = in_value[CUT_W-1:0];
  assign val_elem = ELEMENT_WIDTH'(val_cut);

  assign pos_ok   = 32'(in_position) < DEPTH;

  // Half-open range [lo, hi): mid = lo + (hi - 1 - lo) / 2
  assign span_w = hi_r - lo_r - BW'(1);
  assign mid_w  = lo_r + (span_w >> 1);

  always_ff @(posedge clk) begin
    if (cmd.load_we && pos_ok) begin
      mem[AW'(in_position)] <= val_elem;
    end
    if (cmd.probe) begin
      rdata_r <= mem[AW'(mid_w)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo_r     <= '0;
      hi_r     <= BW'(size_w);
      target_r <= val_elem;
    end else if (cmd.step) begin
      if (rdata_r < target_r) begin
        lo_r <= mid_r + BW'(1);
      end else begin
        hi_r <= mid_r;
      end
    end
    if (cmd.probe) begin
      mid_r <= mid_w;
    end
  end

  assign sts.empty = !(lo_r < hi_r);
  assign sts.equal = (rdata_r == target_r);

endmodule

/* design/smbs_ctrl.sv */
// Search controller: request handshake, probe sequencing and result register.
module smbs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_action,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_found,
  output smbs_pkg::cmd_t cmd,
  input  smbs_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       found_r, found_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r, out_found_nxt;
  logic       accept;
  logic       is_search;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign is_search = (in_action == smbs_pkg::ACT_SEARCH);

  assign cmd.load_we = accept & !is_search;
  assign cmd.start   = accept & is_search;
  assign cmd.probe   = (state_r == S_PROBE) & !sts.empty;
  assign cmd.step    = (state_r == S_CMP) & !sts.equal;

  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.empty) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.equal) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        // wait for the result slot to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r     <= found_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

endmodule

/* design/smbs_checker.sv */
// Port-level checks for the sorted matrix search core, bound to the top level.
module smbs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready,
  input logic out_found
);

  logic in_acc;
  assign in_acc = in_valid & in_ready;

  // Reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear result and open input");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found))
    else $error("stalled result changed");

  // A search occupies the core: no new request right after it
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == smbs_pkg::ACT_SEARCH) |=> !in_ready)
    else $error("request taken during a search");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == smbs_pkg::ACT_LOAD) && !out_valid |=> !out_valid)
    else $error("result after a load");

  // A search result shows only after the core passes through its probe and done states
  a_search_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_action == smbs_pkg::ACT_SEARCH) && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("search result too early");

endmodule

bind sorted_matrix_binary_search_core smbs_checker u_smbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_found (out_found)
);

/* test/smbs_search_checker.sv */
// Search checker: mirrors the element table and counts, predicts each search flag and compares.
module smbs_search_checker
  import smbs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_action,
  input  logic [POS_W-1:0]            in_position,
  input  logic signed [VALUE_W-1:0]   in_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_found,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [APB_AW-1:0]           paddr,
  input  logic [APB_DW-1:0]           pwdata,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [VALUE_W-1:0] elem_tbl [MAX_ROWS_DEF*MAX_COLS_DEF];
  logic [CNT_W-1:0]          row_cnt;
  logic [CNT_W-1:0]          col_cnt;
  logic                      expected_found_q [$];

  function automatic logic search_hit(input logic signed [VALUE_W-1:0] target);
    int   rows;
    int   cols;
    int   lo;
    int   hi;
    int   mid;
    logic hit;
    rows = (row_cnt > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(row_cnt);
    cols = (col_cnt > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(col_cnt);
    lo   = 0;
    hi   = rows * cols - 1;
    hit  = 1'b0;
    while (!hit && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (elem_tbl[mid] == target) hit = 1'b1;
      else if (elem_tbl[mid] < target) lo = mid + 1;
      else hi = mid - 1;
    end
    return hit;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      row_cnt = COUNT_RESET;
      col_cnt = COUNT_RESET;
      expected_found_q.delete();
      mismatches = 0;
    end else begin
      // results first: a result at the same edge as a search belongs to an older request
      if (out_valid && out_ready) begin
        if (expected_found_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual found=%0b", $time, out_found);
        end else begin
          want = expected_found_q.pop_front();
          if (out_found !== want) begin
            mismatches++;
            $display("%0t: found mismatch, expected %0b, actual %0b", $time, want, out_found);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ROW_COUNT) row_cnt = pwdata[CNT_W-1:0];
        else col_cnt = pwdata[CNT_W-1:0];
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_LOAD) elem_tbl[in_position] = in_value;
        else expected_found_q.push_back(search_hit(in_value));
      end
    end
    pending = expected_found_q.size();
  end

endmodule

/* test/tb_sorted_matrix_binary_search_core.sv */
// Testbench top: drives load/search requests and count writes into the core, gives the verdict.
module tb_sorted_matrix_binary_search_core;
  timeunit 1ns;
  timeprecision 1ps;
  import smbs_pkg::*;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_action;
  logic [POS_W-1:0]          in_position;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_found;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  int mismatches;
  int pending;
  int sent;
  int results;
  int big_left;
  bit idle_tx;

  // what was last loaded at each position, used to pick search targets
  logic signed [VALUE_W-1:0] shadow [MAX_ROWS_DEF*MAX_COLS_DEF];

  sorted_matrix_binary_search_core u_top (.*);

  smbs_search_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(input logic act, input logic [POS_W-1:0] pos,
                              input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = idle_tx ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_position <= pos;
    in_value    <= val;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (act == ACT_LOAD) shadow[pos] = val;
    sent++;
  endtask

  // hold requests until every search has answered, then let the core go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] vals [2];
    vals[0] = r;
    vals[1] = c;
    for (int i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {(i == 0) ? REG_ROW_COUNT : REG_COL_COUNT, 2'b00};
      pwdata  <= APB_DW'(vals[i]);
      @(posedge clk);
      penable <= 1'b1;
      do @(negedge clk); while (!pready);
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // spread 0: tight values with duplicates, 1: mid range, 2: full range ending at the extremes
  task automatic load_region(input int n, input int spread, input bit ordered);
    longint v;
    longint top_step;
    case (spread)
      0: begin
        v        = longint'($urandom_range(0, 40)) - 20;
        top_step = 2;
      end
      1: begin
        v        = longint'($signed($urandom)) / 2;
        top_step = 5000;
      end
      default: begin
        v        = -64'sd2147483648;
        top_step = 64'd4294967295 / n;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (spread > 1 && i == n - 1) v = 2147483647;
      if (ordered) send_request(ACT_LOAD, POS_W'(i), VALUE_W'(v));
      else send_request(ACT_LOAD, POS_W'(i), $urandom);
      v = v + longint'($urandom_range(0, 32'(top_step)));
      if (v > 2147483647) v = 2147483647;
    end
    // stray loads outside the live range
    repeat ($urandom_range(0, 2))
      if (n < MAX_ROWS_DEF * MAX_COLS_DEF)
        send_request(ACT_LOAD, POS_W'($urandom_range(n, 255)), $urandom);
  endtask

  task automatic search_pick(input int n);
    int                        idx;
    logic signed [VALUE_W-1:0] t;
    idx = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: t = shadow[idx];
      6: t = shadow[idx] + 1;
      7: t = shadow[idx] - 1;
      8: t = $urandom;
      default: t = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
    send_request(ACT_SEARCH, POS_W'($urandom), t);
  endtask

  task automatic random_phase();
    int r;
    int c;
    int n;
    int swap_tmp;
    case ($urandom_range(0, 9))
      0: begin
        r = 0;
        c = $urandom_range(0, 31);
      end
      1: begin
        r = $urandom_range(17, 31);
        c = $urandom_range(1, 2);
      end
      2: if (big_left > 0) begin
        big_left--;
        r = $urandom_range(8, 31);
        c = $urandom_range(8, 16);
      end else begin
        r = 2;
        c = 3;
      end
      default: begin
        r = $urandom_range(1, 5);
        c = $urandom_range(1, 5);
      end
    endcase
    if ($urandom_range(0, 1)) begin
      swap_tmp = r;
      r        = c;
      c        = swap_tmp;
    end
    n = ((r > MAX_ROWS_DEF) ? MAX_ROWS_DEF : r) * ((c > MAX_COLS_DEF) ? MAX_COLS_DEF : c);
    settle();
    idle_tx = ($urandom_range(0, 3) != 0);
    set_geometry(CNT_W'(r), CNT_W'(c));
    if (n > 0) load_region(n, $urandom_range(0, 2), $urandom_range(0, 4) != 0);
    repeat ($urandom_range(6, 16)) search_pick(n);
  endtask

  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      // two long holds so the core backs up and stalls its input
      if (results == 40 || results == 250) gap = 120;
      else if ((results % 150) < 30) gap = 0;
      else gap = $urandom_range(0, 4);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      results++;
    end
  end

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= ACT_LOAD;
    in_position <= '0;
    in_value    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    idle_tx  = 1'b1;
    sent     = 0;
    big_left = 2;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 1x1: only position 0 is live
    send_request(ACT_LOAD, 8'd0, -32'sd5);
    send_request(ACT_SEARCH, 8'hff, -32'sd5);
    send_request(ACT_SEARCH, 8'h00, 32'sd6);
    send_request(ACT_SEARCH, 8'h5a, 32'sh8000_0000);
    send_request(ACT_SEARCH, 8'ha5, 32'sh7fff_ffff);

    // fill the whole table so no later search reads an unloaded entry
    settle();
    set_geometry(5'd16, 5'd16);
    load_region(MAX_ROWS_DEF * MAX_COLS_DEF, 2, 1'b1);
    send_request(ACT_SEARCH, 8'h00, 32'sh8000_0000);
    send_request(ACT_SEARCH, 8'h01, 32'sh7fff_ffff);
    send_request(ACT_SEARCH, 8'h02, shadow[127]);
    send_request(ACT_SEARCH, 8'h03, shadow[200] + 1);
    send_request(ACT_SEARCH, 8'h04, 32'sd0);

    // empty range
    settle();
    set_geometry(5'd0, 5'd16);
    send_request(ACT_SEARCH, 8'h10, shadow[0]);

    // counts above the table geometry clamp
    settle();
    set_geometry(5'd31, 5'd31);
    send_request(ACT_SEARCH, 8'h20, shadow[255]);
    send_request(ACT_SEARCH, 8'h21, shadow[64]);

    settle();
    set_geometry(5'd16, 5'd0);
    send_request(ACT_SEARCH, 8'h30, shadow[3]);

    settle();
    set_geometry(5'd1, 5'd16);
    send_request(ACT_SEARCH, 8'h40, shadow[15]);
    send_request(ACT_SEARCH, 8'h41, shadow[16]);

    settle();
    set_geometry(5'd16, 5'd1);
    send_request(ACT_SEARCH, 8'h50, shadow[15]);
    send_request(ACT_SEARCH, 8'h51, shadow[0]);

    while (sent < 1250) random_phase();

    settle();
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
